>>> sv/crc32_incremental_64bit_top_macros.svh
// Assertion macros for the incremental CRC-32 block.
// Included by the top level; no other dependencies.
`ifndef CRC32_INCREMENTAL_64BIT_TOP_MACROS_SVH
`define CRC32_INCREMENTAL_64BIT_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define CRC32I_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define CRC32I_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CRC32I_ASSERT_IMP(lbl, ante, cons, msg)
`define CRC32I_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> sv/crc32i_pkg.sv
// Shared constants and the serial CRC-32 reference function.
// Used at elaboration by the lanes to build their XOR columns; no dependencies.
package crc32i_pkg;

    localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
    localparam int          MAX_BYTES     = 16;
    localparam int          MAX_DATA_BITS = 8 * MAX_BYTES;

    // Byte-serial reflected CRC update over the low nbytes of data.
    function automatic logic [31:0] crc32i_advance(
        input logic [31:0]              crc_in,
        input logic [MAX_DATA_BITS-1:0] data,
        input int                       nbytes
    );
        logic [31:0] crc;
        crc = crc_in;
        for (int k = 0; k < MAX_BYTES; k++)
        begin
            if (k < nbytes)
            begin
                crc[7:0] = crc[7:0] ^ data[8*k +: 8];
                for (int b = 0; b < 8; b++)
                begin
                    crc = (crc >> 1) ^ (crc[0] ? CRC_POLY : 32'h0);
                end
            end
        end
        return crc;
    endfunction

endpackage

>>> sv/crc32i_lane.sv
// One lane: CRC register advanced over exactly LANE_BYTES bytes as a flat XOR network.
// Depends on crc32i_pkg for the polynomial and the serial function used to build columns.
module crc32i_lane
    import crc32i_pkg::*;
#(
    parameter int LANE_BYTES = 1
)
(
    input  logic [31:0]             crc_in,
    input  logic [8*LANE_BYTES-1:0] data,
    output logic [31:0]             crc_out
);

    localparam int DATA_BITS = 8 * LANE_BYTES;

    typedef logic [31:0][31:0]          reg_cols_t;
    typedef logic [DATA_BITS-1:0][31:0] data_cols_t;

    // Column j: response to register bit j alone.
    function automatic reg_cols_t build_reg_cols();
        reg_cols_t cols;
        for (int j = 0; j < 32; j++)
        begin
            cols[j] = crc32i_advance(32'h1 << j, '0, LANE_BYTES);
        end
        return cols;
    endfunction

    // Column i: response to data bit i alone, register zero.
    function automatic data_cols_t build_data_cols();
        data_cols_t cols;
        for (int i = 0; i < DATA_BITS; i++)
        begin
            cols[i] = crc32i_advance(32'h0, MAX_DATA_BITS'(1) << i, LANE_BYTES);
        end
        return cols;
    endfunction

    localparam reg_cols_t  REG_COLS  = build_reg_cols();
    localparam data_cols_t DATA_COLS = build_data_cols();

    always_comb
    begin
        crc_out = '0;
        for (int j = 0; j < 32; j++)
        begin
            crc_out = crc_out ^ (REG_COLS[j] & {32{crc_in[j]}});
        end
        for (int i = 0; i < DATA_BITS; i++)
        begin
            crc_out = crc_out ^ (DATA_COLS[i] & {32{data[i]}});
        end
    end

endmodule

>>> sv/crc32i_merge.sv
// Merge stage: saturates the byte count and picks the matching lane result.
// Depends on crc32i_pkg; fed by the crc32i_lane instances.
module crc32i_merge
    import crc32i_pkg::*;
#(
    parameter int BYTES_PER_ITEM = 8
)
(
    input  logic [31:0] lane_crc [0:BYTES_PER_ITEM],
    input  logic [3:0]  byte_count,
    output logic [31:0] crc_next
);

    localparam int SEL_W = $clog2(BYTES_PER_ITEM + 1);

    logic [SEL_W-1:0] sel;

    always_comb
    begin
        if (int'(byte_count) > BYTES_PER_ITEM)
        begin
            sel = SEL_W'(BYTES_PER_ITEM);
        end
        else
        begin
            sel = SEL_W'(byte_count);
        end
        crc_next = lane_crc[sel];
    end

endmodule

>>> sv/crc32_incremental_64bit_top.sv
// Incremental reflected CRC-32 (poly 0xEDB88320), up to BYTES_PER_ITEM bytes per word.
// crc_value is registered: it is valid in the cycle after the word is accepted.
// Throughput: 1 word per cycle while in_stall is low; the lane XOR network feeds
// running_crc_reg combinationally, so back-to-back words chain without a bubble.
// Reset (rst_n low, async): running CRC set to all ones, output register emptied.
`include "crc32_incremental_64bit_top_macros.svh"
module crc32_incremental_64bit_top
    import crc32i_pkg::*;
#(
    parameter int BYTES_PER_ITEM = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        first,
    input  logic [31:0] seed,
    input  logic [63:0] data_word,
    input  logic [3:0]  byte_count,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] crc_value
);

    localparam int DATA_BITS = 8 * BYTES_PER_ITEM;

    logic              accept;
    logic [31:0]       crc_start;
    logic [DATA_BITS-1:0] lane_data;
    logic [31:0]       lane_crc [0:BYTES_PER_ITEM];
    logic [31:0]       merged_crc;

    logic [31:0]       running_crc_reg;
    logic [31:0]       running_crc_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [31:0]       crc_value_reg;
    logic [31:0]       crc_value_next;

    // The output register takes a new word whenever it is empty or being drained,
    // so the input side only stalls while a result sits unclaimed.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // A first word restarts from the complemented seed.
    assign crc_start = first ? ~seed : running_crc_reg;

    // Bytes past bit 63 read as zero when the lane count exceeds eight.
    generate
        if (DATA_BITS > 64)
        begin : g_data_wide
            assign lane_data = {{(DATA_BITS-64){1'b0}}, data_word};
        end
        else
        begin : g_data_narrow
            assign lane_data = data_word[DATA_BITS-1:0];
        end
    endgenerate

    // Lane 0 is the zero-byte case: register passes through.
    assign lane_crc[0] = crc_start;

    // Lane c absorbs exactly c bytes; all lanes run in parallel on the same word.
    generate
        for (genvar c = 1; c <= BYTES_PER_ITEM; c++)
        begin : g_lane
            crc32i_lane #(
                .LANE_BYTES (c)
            ) u_lane (
                .crc_in  (crc_start),
                .data    (lane_data[8*c-1:0]),
                .crc_out (lane_crc[c])
            );
        end
    endgenerate

    crc32i_merge #(
        .BYTES_PER_ITEM (BYTES_PER_ITEM)
    ) u_merge (
        .lane_crc   (lane_crc),
        .byte_count (byte_count),
        .crc_next   (merged_crc)
    );

    always_comb
    begin
        running_crc_next = running_crc_reg;
        out_valid_next   = out_valid_reg && out_stall;
        crc_value_next   = crc_value_reg;
        if (accept)
        begin
            running_crc_next = merged_crc;
            out_valid_next   = 1'b1;
            crc_value_next   = ~merged_crc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_crc_reg <= '1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            running_crc_reg <= running_crc_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Result payload, no reset needed.
    always_ff @(posedge clk)
    begin
        crc_value_reg <= crc_value_next;
    end

    assign out_valid = out_valid_reg;
    assign crc_value = crc_value_reg;

    `CRC32I_ASSERT_NXT(a_accept_fills_out, accept, out_valid, "accepted word produced no result")
    `CRC32I_ASSERT_NXT(a_out_matches_state, accept, crc_value == ~running_crc_reg, "result and running CRC disagree")
    `CRC32I_ASSERT_NXT(a_state_holds_idle, !accept, running_crc_reg == $past(running_crc_reg), "running CRC moved without a word")
    `CRC32I_ASSERT_NXT(a_empty_first_seed, accept && first && byte_count == 4'd0, crc_value == $past(seed), "empty first word did not return seed")

endmodule

>>> sim/tb.sv
// Self-checking testbench for the incremental CRC-32 block (crc32_incremental_64bit_top).
// Needs only the block's RTL and its package; the expected CRCs come from a bitwise
// predictor inside this file.
`timescale 1ns / 100ps

module tb;

    localparam int          BYTES_PER_WORD = 8;
    localparam logic [31:0] CRC32_POLY     = 32'hEDB88320;
    // Worst correct run: about 1600 words at their longest gap and stall; keep a wide margin.
    localparam int          CYCLE_LIMIT    = 400000;

    // DUT-facing signals; every input starts at a known value.
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic        first      = 1'b0;
    logic [31:0] seed       = 32'h0;
    logic [63:0] data_word  = 64'h0;
    logic [3:0]  byte_count = 4'h0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [31:0] crc_value;

    // Predictor state and the CRCs still owed by the block, oldest first.
    logic [31:0] crc_running = 32'hFFFFFFFF;
    logic [31:0] crc_expected[$];

    // Run bookkeeping.
    int  cycle_count    = 0;
    int  error_count    = 0;
    int  words_sent     = 0;
    int  messages_sent  = 0;
    int  results_seen   = 0;
    int  zero_len_words = 0;
    int  clipped_words  = 0;
    int  stall_left     = 0;
    bit  no_idle        = 1'b0;   // set for back-to-back stretches on both sides

    crc32_incremental_64bit_top #(
        .BYTES_PER_ITEM(BYTES_PER_WORD)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .first     (first),
        .seed      (seed),
        .data_word (data_word),
        .byte_count(byte_count),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .crc_value (crc_value)
    );

    always #2 clk = ~clk;

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d CRCs still pending",
                     cycle_count, crc_expected.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Reflected CRC-32 advanced one message bit at a time, LSB of the word first.
    // Counts above the word width clip to the word width; zero absorbs nothing.
    function automatic logic [31:0] crc_fold(
        input logic [31:0] crc_reg,
        input logic [63:0] data,
        input logic [3:0]  count
    );
        int   nbits;
        logic fb;
        nbits = 8 * ((count > BYTES_PER_WORD) ? BYTES_PER_WORD : int'(count));
        for (int i = 0; i < 64; i++)
        begin
            if (i < nbits)
            begin
                fb      = crc_reg[0] ^ data[i];
                crc_reg = crc_reg >> 1;
                if (fb)
                    crc_reg = crc_reg ^ CRC32_POLY;
            end
        end
        return crc_reg;
    endfunction

    // Wait drawn per word by either side: none on half the draws, else a random wait from one of two ranges.
    function automatic int draw_wait();
        if (no_idle)
            return 0;
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 18);
            1:       return $urandom_range(0, 2);
            default: return 0;
        endcase
    endfunction

    // Payload picks lean on the extremes now and then.
    function automatic logic [63:0] pick_data();
        case ($urandom_range(0, 9))
            0:       return 64'h0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [31:0] pick_seed();
        case ($urandom_range(0, 3))
            0:       return 32'h0;          // fresh message
            1:       return 32'hFFFFFFFF;
            default: return $urandom;       // arbitrary seed
        endcase
    endfunction

    function automatic logic [3:0] pick_len();
        if ($urandom_range(0, 2) != 0)
            return 4'd8;
        return 4'($urandom_range(1, 8));
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] exp_crc,
                                   input logic [31:0] act_crc);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] %s: expected %08h, got %08h", $realtime, what, exp_crc, act_crc);
    endtask

    // Send one word: idle for a drawn gap, then hold the word until it is taken.
    // in_valid is only lowered ahead of a gap, so back-to-back words never see a
    // low-then-high pair of updates in the same time step.
    task automatic send_word(input logic f, input logic [31:0] s, input logic [63:0] d,
                             input logic [3:0] n);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        first      <= f;
        seed       <= s;
        data_word  <= d;
        byte_count <= n;
        // in_stall read here is the value the block saw at this edge.
        do
            @(posedge clk);
        while (in_stall);
        // Accepted: advance the predictor exactly as the block should.
        crc_running = crc_fold(f ? ~s : crc_running, d, n);
        crc_expected.push_back(~crc_running);
        words_sent++;
        if (n == 4'd0)
            zero_len_words++;
        if (n > BYTES_PER_WORD)
            clipped_words++;
    endtask

    // Stop sending and let every outstanding CRC come back.
    // Nothing pending means in_valid is already low, so it is left alone.
    task automatic wait_drained();
        if (crc_expected.size() != 0)
        begin
            in_valid <= 1'b0;
            while (crc_expected.size() != 0)
                @(posedge clk);
        end
    endtask

    // Output side: check each accepted CRC, then draw a stall for the next one.
    // The stall runs whether or not out_valid is up, so it lands on every phase.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (crc_expected.size() == 0)
                    report_mismatch("CRC with nothing pending", 32'h0, crc_value);
                else if (crc_value !== crc_expected[0])
                    report_mismatch("crc_value", crc_expected.pop_front(), crc_value);
                else
                    void'(crc_expected.pop_front());
                stall_left = draw_wait();
            end
            else if (stall_left > 0)
                stall_left--;
            out_stall <= (stall_left > 0);
        end
    end

    // Hand-picked words: extremes, zero and over-long counts, the check string.
    task automatic test_directed();
        // First word after reset starts a message; "12345678" then "9".
        send_word(1'b1, 32'h0, 64'h3837363534333231, 4'd8);
        send_word(1'b0, 32'hDEADBEEF, 64'h39, 4'd1);
        // Zero count: first still loads the seed, continuation changes nothing.
        send_word(1'b1, 32'h0, 64'hFFFFFFFFFFFFFFFF, 4'd0);
        send_word(1'b0, 32'hFFFFFFFF, 64'h0123456789ABCDEF, 4'd0);
        send_word(1'b1, 32'hFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 4'd8);
        send_word(1'b0, 32'h0, 64'h0, 4'd8);
        send_word(1'b1, $urandom, 64'hFFFFFFFFFFFFFFFF, 4'd1);
        // Every partial length.
        for (int n = 2; n < BYTES_PER_WORD; n++)
            send_word(1'b0, $urandom, {$urandom, $urandom}, 4'(n));
        // Counts past the word width clip to eight bytes.
        send_word(1'b0, 32'h0, {$urandom, $urandom}, 4'd9);
        send_word(1'b0, 32'h0, {$urandom, $urandom}, 4'd15);
        send_word(1'b1, 32'h12345678, 64'hFFFFFFFFFFFFFFFF, 4'd15);
        send_word(1'b0, 32'hFFFFFFFF, 64'h0, 4'd0);
        send_word(1'b1, 32'h0, 64'h0, 4'd8);
        send_word(1'b1, 32'hFFFFFFFF, 64'h0, 4'd0);
        send_word(1'b0, 32'h0, 64'h8000000000000001, 4'd8);
        wait_drained();
    endtask

    // Well-formed messages: a first word with a seed, then continuation words.
    task automatic test_messages(input int target);
        int stop_at;
        int len;
        stop_at = words_sent + target;
        while (words_sent < stop_at)
        begin
            len     = $urandom_range(1, 12);
            no_idle = ($urandom_range(0, 5) == 0);
            send_word(1'b1, pick_seed(), pick_data(), pick_len());
            for (int i = 1; i < len; i++)
                send_word(1'b0, $urandom, pick_data(), pick_len());
            messages_sent++;
            // Sender holds off now and then until the pipe is empty.
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end
        no_idle = 1'b0;
        wait_drained();
    endtask

    // Anything goes: random first flags and counts across the full 4-bit range.
    task automatic test_noise(input int count);
        for (int i = 0; i < count; i++)
            send_word($urandom_range(0, 3) == 0, $urandom, pick_data(),
                      4'($urandom_range(0, 15)));
        wait_drained();
    endtask

    // Back-to-back words with no idling on either side.
    task automatic test_back_to_back(input int count);
        no_idle = 1'b1;
        for (int i = 0; i < count; i++)
            send_word($urandom_range(0, 7) == 0, pick_seed(), pick_data(), pick_len());
        no_idle = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_messages(1080);
        test_noise(250);
        test_back_to_back(150);

        wait_drained();
        // Allow for the output register and any stray extra CRC.
        repeat (8) @(posedge clk);

        $display("Sent %0d words (%0d seeded messages), checked %0d CRCs", words_sent,
                 messages_sent, results_seen);
        $display("Zero-length words: %0d, over-long counts: %0d, errors: %0d",
                 zero_len_words, clipped_words, error_count);
        if (error_count == 0 && crc_expected.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
